// ----- hdl/ps2_mouse_packet_cursor_macros.svh -----
// Assertion helpers shared by the ps2 mouse cursor modules.
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PMC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define PMC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define PMC_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define PMC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/ps2mc_pkg.sv -----
`default_nettype none

package ps2mc_pkg;

   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int BTN_W = 3;

   localparam int SCREEN_COLS_DEF = 80;
   localparam int SCREEN_ROWS_DEF = 25;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       aux_data_ready;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] old_col;
      logic [ROW_W-1:0] old_row;
      logic [COL_W-1:0] new_col;
      logic [ROW_W-1:0] new_row;
      logic [BTN_W-1:0] pressed_mask;
      logic [BTN_W-1:0] released_mask;
      logic [BTN_W-1:0] button_levels;
   } rsp_type;

   // One assembled packet, handed from the byte front to the cursor back.
   typedef struct packed {
      logic [BTN_W-1:0] buttons;
      logic [7:0]       x_delta;
      logic [7:0]       y_delta;
   } pkt_type;

endpackage

`default_nettype wire

// ----- hdl/ps2_mouse_packet_cursor.sv -----
// PS/2 mouse packet decoder with a text-cell cursor.
// Request channel (req_valid / req_stall / req_payload) takes one controller
// byte per beat. Bytes with aux_data_ready low are dropped. Mouse bytes are
// grouped header, X delta, Y delta by a position counter (no sync check).
// The third byte of a packet yields one response beat on rsp_valid /
// rsp_stall / rsp_payload: old and new cursor cell (clamped to the screen),
// button press/release masks and current button levels.
// Throughput: one byte per clock cycle while req_stall is low, set by the byte
// front end; the cursor unit finishes one packet per cycle unless rsp_stall
// holds a pending response. After the edge that accepts the third byte, the
// packet waits in the two-entry packet queue and is then loaded into the output
// register that drives rsp_valid / rsp_payload.
// Reset clears the byte position, puts the cursor at the screen center and
// clears the button history. While rsp_stall is high the response holds; the
// queue keeps absorbing packets and req_stall rises only when it is full.
`default_nettype none

module ps2_mouse_packet_cursor
   import ps2mc_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic    q_full, q_push, q_pop, q_not_empty;
   pkt_type q_wdata, q_rdata;

   ps2mc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (q_full),
      .push        (q_push),
      .push_data   (q_wdata)
   );

   ps2mc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rdata)
   );

   ps2mc_back #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pkt_valid   (q_not_empty),
      .pkt         (q_rdata),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- hdl/ps2mc_front.sv -----
`default_nettype none
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2mc_front
   import ps2mc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   input  wire logic    queue_full,
   output logic         push,
   output pkt_type      push_data
);

   localparam logic [1:0] POS_HEAD = 2'd0;
   localparam logic [1:0] POS_X    = 2'd1;
   localparam logic [1:0] POS_Y    = 2'd2;

   logic [1:0]       pos_ff, pos_in;
   logic [BTN_W-1:0] header_ff, header_in;
   logic [7:0]       x_ff, x_in;
   logic             take;

   assign req_stall = queue_full;
   assign take      = req_valid && !queue_full && req_payload.aux_data_ready;

   always_comb begin
      pos_in    = pos_ff;
      header_in = header_ff;
      x_in      = x_ff;
      push      = 1'b0;
      if (take) begin
         unique case (pos_ff)
            POS_X: begin
               x_in   = req_payload.data_byte;
               pos_in = POS_Y;
            end
            POS_Y: begin
               push   = 1'b1;
               pos_in = POS_HEAD;
            end
            default: begin
               // header; only the button bits are kept
               header_in = req_payload.data_byte[BTN_W-1:0];
               pos_in    = POS_X;
            end
         endcase
      end
   end

   assign push_data.buttons = header_ff;
   assign push_data.x_delta = x_ff;
   assign push_data.y_delta = req_payload.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HEAD;
      end else begin
         pos_ff <= pos_in;
      end
      header_ff <= header_in;
      x_ff      <= x_in;
   end

   `PMC_ASSERT_IMP(a_pos_legal, clock, reset, 1'b1, pos_ff != 2'd3)
   `PMC_ASSERT_IMP(a_push_at_y, clock, reset, push, (pos_ff == POS_Y) && !queue_full)

endmodule

`default_nettype wire

// ----- hdl/ps2mc_queue.sv -----
`default_nettype none
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2mc_queue
   import ps2mc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire pkt_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output pkt_type      pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   pkt_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   `PMC_ASSERT_IMP(a_no_overflow, clock, reset, push, !full)
   `PMC_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= FULL_CNT)

endmodule

`default_nettype wire

// ----- hdl/ps2mc_back.sv -----
`default_nettype none
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2mc_back
   import ps2mc_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pkt_valid,
   input  wire pkt_type pkt,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam logic [COL_W-1:0] COL_RESET = COL_W'(SCREEN_COLS / 2);
   localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(SCREEN_ROWS / 2);
   localparam logic [COL_W-1:0] COL_MAX   = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(SCREEN_ROWS - 1);
   localparam logic signed [9:0] COL_LIM  = 10'(SCREEN_COLS);
   localparam logic signed [9:0] ROW_LIM  = 10'(SCREEN_ROWS);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [BTN_W-1:0] btn_ff, btn_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic signed [9:0] col_sum, row_sum;

   assign pop = pkt_valid && (!rsp_valid_ff || !rsp_stall);

   assign col_sum = $signed({3'b000, col_ff}) + $signed({{2{pkt.x_delta[7]}}, pkt.x_delta});
   assign row_sum = $signed({5'b00000, row_ff}) - $signed({{2{pkt.y_delta[7]}}, pkt.y_delta});

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      btn_in       = btn_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         if (col_sum < 0) begin
            col_in = '0;
         end else if (col_sum >= COL_LIM) begin
            col_in = COL_MAX;
         end else begin
            col_in = col_sum[COL_W-1:0];
         end
         if (row_sum < 0) begin
            row_in = '0;
         end else if (row_sum >= ROW_LIM) begin
            row_in = ROW_MAX;
         end else begin
            row_in = row_sum[ROW_W-1:0];
         end
         btn_in               = pkt.buttons;
         rsp_in.old_col       = col_ff;
         rsp_in.old_row       = row_ff;
         rsp_in.new_col       = col_in;
         rsp_in.new_row       = row_in;
         rsp_in.pressed_mask  = pkt.buttons & ~btn_ff;
         rsp_in.released_mask = btn_ff & ~pkt.buttons;
         rsp_in.button_levels = pkt.buttons;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= COL_RESET;
         row_ff       <= ROW_RESET;
         btn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         btn_ff       <= btn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PMC_ASSERT_IMP(a_col_range, clock, reset, 1'b1, col_ff <= COL_MAX)
   `PMC_ASSERT_IMP(a_row_range, clock, reset, 1'b1, row_ff <= ROW_MAX)
   `PMC_ASSERT_IMP(a_edges_disjoint, clock, reset, rsp_valid_ff,
                   (rsp_ff.pressed_mask & rsp_ff.released_mask) == '0)
   `PMC_ASSERT_NXT(a_cursor_tracks, clock, reset, pop,
                   rsp_valid_ff && (rsp_ff.new_col == col_ff) && (rsp_ff.new_row == row_ff))

endmodule

`default_nettype wire
